>>> sv/diff_drive_odometry_update_unit_assert.svh
// assertion macros shared by the odometry update rtl
// no dependencies
`ifndef DIFF_DRIVE_ODOMETRY_UPDATE_UNIT_ASSERT_SVH
`define DIFF_DRIVE_ODOMETRY_UPDATE_UNIT_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define DDO_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DDO_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/ddo_pkg.sv
// shared types, constants and tables for the odometry update
// no dependencies
package ddo_pkg;

    localparam int CordicIters = 16;
    localparam int IterCnt = (CordicIters < 24) ? CordicIters : 24;
    localparam int IterW = 5;
    localparam int GainQ30 = 652032874;
    localparam logic [15:0] CircReset = 16'd9059;
    localparam logic [23:0] TpmReset = 24'd107530;

    // serial multiplier widths
    localparam int MulAW = 48;   // multiplicand
    localparam int MulBW = 32;   // multiplier, consumed lsb first
    localparam int MulPW = 80;

    // cordic datapath width (q.29 values plus growth)
    localparam int CordW = 40;

    localparam logic [0:0] CfgCirc = 1'b0;
    localparam logic [0:0] CfgTpm = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DA,
        ST_DB,
        ST_DYAW,
        ST_GAIN,
        ST_PREP,
        ST_ROT,
        ST_ACC,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic [MulAW-1:0] a;
        logic [MulBW-1:0] b;
    } mul_req_t;

    function automatic logic [31:0] atan_turns(input logic [IterW-1:0] i);
        logic [31:0] r;
        case (i)
            5'd0: r = 32'd536870912;
            5'd1: r = 32'd316933406;
            5'd2: r = 32'd167458907;
            5'd3: r = 32'd85004756;
            5'd4: r = 32'd42667331;
            5'd5: r = 32'd21354465;
            5'd6: r = 32'd10679838;
            5'd7: r = 32'd5340245;
            5'd8: r = 32'd2670163;
            5'd9: r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

>>> sv/ddo_serial_mul.sv
// bit-serial signed x unsigned multiplier, one multiplier bit per cycle
// depends on ddo_pkg
module ddo_serial_mul (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  ddo_pkg::mul_req_t         req,
    output logic                      done,
    output logic signed [ddo_pkg::MulPW-1:0] prod
);
    import ddo_pkg::*;

    logic signed [MulPW-1:0] acc_reg, acc_next;
    logic signed [MulPW-1:0] mcand_reg, mcand_next;
    logic [MulBW-1:0] mplier_reg, mplier_next;
    logic [5:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;

    // multiplicand is signed, multiplier unsigned; add-shift one bit a cycle
    always_comb begin
        acc_next = acc_reg;
        mcand_next = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            acc_next = '0;
            mcand_next = MulPW'(signed'(req.a));
            mplier_next = req.b;
            cnt_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (mplier_reg[0]) begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next = mcand_reg <<< 1;
            mplier_next = mplier_reg >> 1;
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(MulBW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        acc_reg <= acc_next;
        mcand_reg <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;
endmodule

>>> sv/ddo_cordic.sv
// rotation-mode cordic, one micro-rotation per cycle with a barrel shifter on each of x and y
// depends on ddo_pkg and the assertion header
module ddo_cordic (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [ddo_pkg::CordW-1:0]  x_in,
    input  logic signed [32:0]                z_in,
    output logic                              done,
    output logic signed [ddo_pkg::CordW-1:0]  x_out,
    output logic signed [ddo_pkg::CordW-1:0]  y_out
);
    import ddo_pkg::*;
    `include "diff_drive_odometry_update_unit_assert.svh"

    logic signed [CordW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [34:0] z_reg, z_next;
    logic [IterW-1:0] i_reg, i_next;
    logic busy_reg, busy_next, done_reg, done_next;
    logic signed [CordW-1:0] sx, sy;

    assign sx = x_reg >>> i_reg;
    assign sy = y_reg >>> i_reg;

    always_comb begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        i_next = i_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            x_next = x_in;
            y_next = '0;
            z_next = 35'(z_in);
            i_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!z_reg[34]) begin
                x_next = x_reg - sy;
                y_next = y_reg + sx;
                z_next = z_reg - 35'(signed'({1'b0, atan_turns(i_reg)}));
            end else begin
                x_next = x_reg + sy;
                y_next = y_reg - sx;
                z_next = z_reg + 35'(signed'({1'b0, atan_turns(i_reg)}));
            end
            i_next = i_reg + 1'b1;
            if (i_reg == IterW'(IterCnt - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            i_reg <= i_next;
        end
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done = done_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;

    `DDO_ASSERT_NEXT(a_cordic_done_once, aclk, aresetn, done_reg, !done_reg, "cordic done twice")
    `DDO_ASSERT_IMP(a_cordic_iter_range, aclk, aresetn, busy_reg, i_reg < IterW'(IterCnt), "cordic index out of range")
    `DDO_ASSERT_IMP(a_cordic_done_idle, aclk, aresetn, done_reg, !busy_reg, "cordic done while busy")
endmodule

>>> sv/diff_drive_odometry_update_unit.sv
// differential-drive odometry update, one item at a time: each accepted item
// runs through four bit-serial products, a fold step, the 16-step cordic with
// its load, an accumulate step, an output load and a return to idle.
// the result sits in an output register; a new item is taken while it waits.
// aresetn (synchronous, active low) clears the pose to zero and restores the
// register reset values.
module diff_drive_odometry_update_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // rev_first[15:0], rev_second[31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // pos_x[31:0], pos_y[63:32], heading[79:64]
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [23:0] cfg_wdata
);
    import ddo_pkg::*;
    `include "diff_drive_odometry_update_unit_assert.svh"

    state_t state_reg, state_next;
    logic [15:0] circ_reg;
    logic [23:0] tpm_reg;
    logic signed [31:0] x_acc_reg, x_acc_next, y_acc_reg, y_acc_next;
    logic [15:0] yaw_reg, yaw_next;
    logic signed [15:0] ra_reg, rb_reg;
    logic signed [31:0] da_reg, da_next;
    logic signed [31:0] db_reg, db_next;
    logic signed [47:0] dyaw_reg, dyaw_next;
    logic signed [32:0] z_reg, z_next;
    logic signed [CordW-1:0] cx_reg, cx_next;
    logic ovalid_reg, ovalid_next;
    logic [79:0] odata_reg, odata_next;
    mul_req_t mreq;
    logic mdone;
    logic signed [MulPW-1:0] mprod;
    logic cstart, cdone;
    logic signed [CordW-1:0] cx_out, cy_out;

    logic signed [32:0] sum2;
    logic signed [47:0] dyaw_r13;
    logic signed [47:0] dyaw_r28;
    logic [31:0] mid, mid_adj;
    logic signed [MulPW-1:0] gain_r;
    logic signed [CordW-1:0] rx, ry;
    logic signed [33:0] sx_sum, sy_sum;

    ddo_serial_mul u_mul (
        .aclk(aclk), .aresetn(aresetn), .req(mreq), .done(mdone), .prod(mprod)
    );

    // the cordic loads the folded start values in the same cycle they are formed
    ddo_cordic u_cordic (
        .aclk(aclk), .aresetn(aresetn), .start(cstart), .x_in(cx_next), .z_in(z_next),
        .done(cdone), .x_out(cx_out), .y_out(cy_out)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign sum2 = 33'(da_reg) + 33'(db_reg);
    assign dyaw_r13 = (dyaw_reg + 48'sd4096) >>> 13;
    assign dyaw_r28 = (dyaw_reg + (48'sd1 <<< 27)) >>> 28;
    assign mid = {yaw_reg, 16'h0} - dyaw_r13[31:0];
    assign mid_adj = (mid[31] ^ mid[30]) ? (mid + 32'h8000_0000) : mid;
    assign gain_r = (mprod + (MulPW'(1) <<< 29)) >>> 30;
    assign rx = (cx_out + CordW'(4096)) >>> 13;
    assign ry = (cy_out + CordW'(4096)) >>> 13;
    assign sx_sum = 34'(x_acc_reg) + 34'(rx);
    assign sy_sum = 34'(y_acc_reg) + 34'(ry);

    always_comb begin
        state_next = state_reg;
        da_next = da_reg;
        db_next = db_reg;
        dyaw_next = dyaw_reg;
        z_next = z_reg;
        cx_next = cx_reg;
        x_acc_next = x_acc_reg;
        y_acc_next = y_acc_reg;
        yaw_next = yaw_reg;
        ovalid_next = ovalid_reg;
        odata_next = odata_reg;
        mreq = '0;
        cstart = 1'b0;
        if (ovalid_reg && m_tready) begin
            ovalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    mreq.start = 1'b1;
                    mreq.a = 48'(signed'(s_tdata[15:0]));
                    mreq.b = 32'(circ_reg);
                    state_next = ST_DA;
                end
            end
            ST_DA: begin
                if (mdone) begin
                    da_next = mprod[31:0];
                    mreq.start = 1'b1;
                    mreq.a = 48'(rb_reg);
                    mreq.b = 32'(circ_reg);
                    state_next = ST_DB;
                end
            end
            ST_DB: begin
                if (mdone) begin
                    db_next = mprod[31:0];
                    mreq.start = 1'b1;
                    mreq.a = 48'(signed'(mprod[31:0])) - 48'(da_reg);
                    mreq.b = 32'(tpm_reg);
                    state_next = ST_DYAW;
                end
            end
            ST_DYAW: begin
                if (mdone) begin
                    dyaw_next = mprod[47:0];
                    mreq.start = 1'b1;
                    mreq.a = 48'(sum2);
                    mreq.b = 32'(GainQ30);
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN: begin
                if (mdone) begin
                    cx_next = gain_r[CordW-1:0];
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                // fold the angle into the right half plane
                if (mid[31] ^ mid[30]) begin
                    cx_next = -cx_reg;
                end
                z_next = 33'(signed'(mid_adj));
                yaw_next = yaw_reg - dyaw_r28[15:0];
                state_next = ST_ROT;
            end
            ST_ROT: begin
                if (!cstart && cdone) begin
                    if (sx_sum > 34'sh0_7FFF_FFFF) x_acc_next = 32'sh7FFF_FFFF;
                    else if (sx_sum < -34'sh0_8000_0000) x_acc_next = 32'sh8000_0000;
                    else x_acc_next = sx_sum[31:0];
                    if (sy_sum > 34'sh0_7FFF_FFFF) y_acc_next = 32'sh7FFF_FFFF;
                    else if (sy_sum < -34'sh0_8000_0000) y_acc_next = 32'sh8000_0000;
                    else y_acc_next = sy_sum[31:0];
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                if (!ovalid_reg || m_tready) begin
                    ovalid_next = 1'b1;
                    odata_next = {yaw_reg, y_acc_reg, x_acc_reg};
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (state_reg == ST_PREP) begin
            cstart = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            circ_reg <= CircReset;
            tpm_reg <= TpmReset;
            x_acc_reg <= '0;
            y_acc_reg <= '0;
            yaw_reg <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            x_acc_reg <= x_acc_next;
            y_acc_reg <= y_acc_next;
            yaw_reg <= yaw_next;
            ovalid_reg <= ovalid_next;
            if (cfg_we) begin
                case (cfg_index)
                    CfgCirc: circ_reg <= cfg_wdata[15:0];
                    CfgTpm: tpm_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
        if (s_tvalid && s_tready) begin
            rb_reg <= s_tdata[31:16];
        end
        da_reg <= da_next;
        db_reg <= db_next;
        dyaw_reg <= dyaw_next;
        z_reg <= z_next;
        cx_reg <= cx_next;
        odata_reg <= odata_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata = odata_reg;

    `DDO_ASSERT_IMP(a_idle_ready, aclk, aresetn, s_tready, state_reg == ST_IDLE, "ready outside idle")
    `DDO_ASSERT_NEXT(a_out_hold, aclk, aresetn, ovalid_reg && !m_tready, ovalid_reg && $stable(odata_reg), "result dropped")
    `DDO_ASSERT_NEXT(a_accept_starts, aclk, aresetn, s_tvalid && s_tready, state_reg == ST_DA, "accept did not start")
endmodule

>>> dv/diff_drive_odometry_update_unit_tb.sv
// self-checking testbench for the differential-drive odometry update unit
// depends on ddo_pkg and diff_drive_odometry_update_unit
module diff_drive_odometry_update_unit_tb;
    import ddo_pkg::*;

    typedef struct packed {
        logic signed [15:0] rev_second;
        logic signed [15:0] rev_first;
    } wheel_revs_t;

    typedef struct packed {
        logic [15:0] heading;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_x;
    } pose_t;

    localparam longint AtanTbl[24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    logic aclk;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [31:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [79:0] m_tdata;
    logic cfg_we;
    logic cfg_index;
    logic [23:0] cfg_wdata;

    diff_drive_odometry_update_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // predictor state
    logic [15:0] circ_q16;
    logic [23:0] tpm_q16;
    logic signed [31:0] x_pose;
    logic signed [31:0] y_pose;
    logic [15:0] yaw_pose;

    wheel_revs_t rev_queue[$];
    pose_t pose_queue[$];
    int errors = 0;
    int poses_checked = 0;
    int sat_hits = 0;
    bit quiet_mode = 0;
    bit hold_off = 0;
    int src_gap = 0;
    int snk_gap = 0;

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint shr_round(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [31:0] sat32(logic signed [31:0] acc, longint d);
        longint r;
        r = longint'(acc) + d;
        if (r > 64'sd2147483647) return 32'sh7fffffff;
        if (r < -64'sd2147483648) return 32'sh80000000;
        return r[31:0];
    endfunction

    task automatic enqueue_rev(input wheel_revs_t w);
        rev_queue.insert(rev_queue.size(), w);
    endtask

    task automatic predict_pose(input wheel_revs_t w);
        longint da, db, sum, dyaw, cx, cy, z, sx, sy;
        logic [31:0] mid;
        logic [15:0] nyaw;
        pose_t p;
        da = longint'(w.rev_first) * longint'(circ_q16);
        db = longint'(w.rev_second) * longint'(circ_q16);
        sum = da + db;
        dyaw = (db - da) * longint'(tpm_q16);
        mid = {yaw_pose, 16'h0} - 32'(shr_round(dyaw, 13));
        nyaw = yaw_pose - 16'(shr_round(dyaw, 28));
        cx = shr_round(sum * longint'(GainQ30), 30);
        cy = 0;
        if (mid[31:30] == 2'd1 || mid[31:30] == 2'd2) begin
            mid = mid + 32'h80000000;
            cx = -cx;
        end
        z = longint'(signed'(mid));
        for (int i = 0; i < CordicIters && i < 24; i++) begin
            sx = shr_floor(cx, i);
            sy = shr_floor(cy, i);
            if (z >= 0) begin
                cx -= sy; cy += sx; z -= AtanTbl[i];
            end else begin
                cx += sy; cy -= sx; z += AtanTbl[i];
            end
        end
        x_pose = sat32(x_pose, shr_round(cx, 13));
        y_pose = sat32(y_pose, shr_round(cy, 13));
        if (x_pose == 32'sh7fffffff || x_pose == 32'sh80000000) sat_hits++;
        yaw_pose = nyaw;
        p.pos_x = x_pose;
        p.pos_y = y_pose;
        p.heading = yaw_pose;
        pose_queue.insert(pose_queue.size(), p);
    endtask

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // driver: one transfer per accepted item, random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 0;
            s_tdata <= '0;
            src_gap <= 0;
        end else if (s_tvalid && !s_tready) begin
        end else begin
            if (s_tvalid) predict_pose(wheel_revs_t'(s_tdata));
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                s_tvalid <= 0;
            end else if (rev_queue.size() > 0) begin
                s_tdata <= rev_queue.pop_front();
                s_tvalid <= 1;
                if (!quiet_mode && $urandom_range(0, 7) == 0)
                    src_gap <= $urandom_range(1, 6);
            end else begin
                s_tvalid <= 0;
            end
        end
    end

    // monitor and sink stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 0;
            snk_gap <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                pose_t got, want;
                got = pose_t'(m_tdata);
                if (pose_queue.size() == 0) begin
                    $display("%0t: unexpected pose transfer %h", $time, m_tdata);
                    errors++;
                end else begin
                    want = pose_queue.pop_front();
                    poses_checked++;
                    if (got.pos_x !== want.pos_x) begin
                        $display("%0t: pos_x expected %0d actual %0d", $time,
                                 want.pos_x, got.pos_x);
                        errors++;
                    end
                    if (got.pos_y !== want.pos_y) begin
                        $display("%0t: pos_y expected %0d actual %0d", $time,
                                 want.pos_y, got.pos_y);
                        errors++;
                    end
                    if (got.heading !== want.heading) begin
                        $display("%0t: heading expected %0d actual %0d", $time,
                                 want.heading, got.heading);
                        errors++;
                    end
                end
            end
            if (hold_off) begin
                m_tready <= 0;
            end else if (snk_gap > 0) begin
                snk_gap <= snk_gap - 1;
                m_tready <= 0;
            end else begin
                m_tready <= 1;
                if (!quiet_mode && $urandom_range(0, 7) == 0)
                    snk_gap <= $urandom_range(1, 6);
            end
        end
    end

    task automatic write_reg(input logic idx, input logic [23:0] val);
        @(posedge aclk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 0;
        if (idx == CfgCirc) circ_q16 = val[15:0];
        else tpm_q16 = val;
    endtask

    task automatic drain;
        while (rev_queue.size() > 0 || s_tvalid || pose_queue.size() > 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_rev();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($signed($urandom_range(0, 512)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_random(input int n);
        wheel_revs_t w;
        for (int i = 0; i < n; i++) begin
            w.rev_first = rand_rev();
            // straight driving for about one item in three, varied turning otherwise
            w.rev_second = ($urandom_range(0, 2) == 0) ? w.rev_first : rand_rev();
            enqueue_rev(w);
        end
    endtask

    initial begin
        aresetn = 0;
        cfg_we = 0;
        cfg_index = 0;
        cfg_wdata = 0;
        circ_q16 = CircReset;
        tpm_q16 = TpmReset;
        x_pose = 0;
        y_pose = 0;
        yaw_pose = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1;

        // directed: field extremes, straight, pure spin, all quadrants
        enqueue_rev('{16'sh0000, 16'sh0000});
        enqueue_rev('{16'sh1000, 16'sh1000});
        enqueue_rev('{16'sh7fff, 16'sh7fff});
        enqueue_rev('{16'sh8000, 16'sh8000});
        enqueue_rev('{16'sh7fff, 16'sh8000});
        enqueue_rev('{16'sh8000, 16'sh7fff});
        enqueue_rev('{16'sh1000, -16'sh1000});
        enqueue_rev('{16'sh1000, 16'sh0800});
        enqueue_rev('{16'sh0001, 16'shffff});
        enqueue_rev('{16'shffff, 16'shffff});
        enqueue_rev('{16'sh2000, 16'sh0000});
        enqueue_rev('{16'sh0000, 16'sh2000});
        drain();

        // extreme registers: huge circumference and turn rate drive saturation
        write_reg(CfgCirc, 24'hffff);
        write_reg(CfgTpm, 24'hffffff);
        for (int i = 0; i < 8; i++) enqueue_rev('{16'sh7fff, 16'sh7fff});
        enqueue_rev('{16'sh7fff, 16'sh8000});
        queue_random(60);
        drain();

        write_reg(CfgCirc, 24'h0000);
        write_reg(CfgTpm, 24'h000000);
        queue_random(20);
        drain();

        // long receiver stall while the source keeps offering
        write_reg(CfgCirc, 24'(CircReset));
        write_reg(CfgTpm, 24'(TpmReset));
        hold_off = 1;
        queue_random(10);
        repeat (2000) @(posedge aclk);
        hold_off = 0;
        queue_random(500);
        drain();

        write_reg(CfgCirc, 24'($urandom_range(0, 65535)));
        write_reg(CfgTpm, 24'($urandom));
        queue_random(600);
        drain();

        quiet_mode = 1;
        write_reg(CfgCirc, 24'h0001);
        write_reg(CfgTpm, 24'h000001);
        queue_random(100);
        drain();
        write_reg(CfgCirc, 24'(CircReset));
        write_reg(CfgTpm, 24'h800000);
        queue_random(500);
        drain();

        $display("checked %0d pose transfers over six register settings", poses_checked);
        $display("position saturation seen on %0d updates", sat_hits);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #20000000;
        $display("timeout");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
